FILE: src/wmd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the windowed motion detector.
// Used by wmd_axis and windowed_motion_detector; depends on nothing.
package wmd_pkg;

  localparam int WINDOW    = 16;
  localparam int WIN_IDX_W = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SMP_W     = 8;
  localparam int MIN_W     = 5;
  localparam int TOL_W     = 8;
  localparam int LIMIT_W   = 16;
  localparam int TICK_W    = 17;
  localparam int NUM_AXES  = 3;
  localparam int CMP_W     = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  // control from the sequencer to one axis unit
  typedef struct packed {
    logic clear;       // restart: empty the window
    logic push;        // shift in the new sample
    logic rotate;      // evaluation step: rotate the window by one
    logic eval_start;  // drop the still flag before a new evaluation
  } axis_ctl_t;

  // status from one axis unit back to the sequencer
  typedef struct packed {
    logic full;
    logic last_slot;   // one free entry left
    logic still;
  } axis_sts_t;

endpackage

FILE: src/windowed_motion_detector.sv
`timescale 1ns / 1ps
// Top level of the windowed motion detector: request channel, config port,
// sequencer and result register. Depends on wmd_pkg and wmd_axis.
//
// Usage:
//   s_* carries requests: s_tuser is the kind (0 restart, 1 sample tick),
//   s_tdata the three valid/sample pairs. m_* returns one result for every
//   request: status and the axes found not still. cfg_* writes the three
//   registers (0 min_similar, 1 similar_tolerance, 2 max_watch_ticks) and is
//   ready whenever out of reset; write it only while no request is in progress.
//   A request is taken only while the sequencer is idle. Restart, fill and
//   final-status requests go from idle to the write state, which loads the
//   result and m_tvalid into registers once the output register is free and
//   returns to idle. A tick while watching runs the window check first: each
//   axis rotates its window through its own compare unit, one candidate per
//   cycle, until every entry has been the candidate; then the write state
//   registers the result as above.
//   When the receiver stalls, the result holds in the output register; the
//   next request may be taken meanwhile, and its result waits until the
//   register frees. Reset clears phase, fill and tick counts, loads 8, 1, 1000.
module windowed_motion_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // x_valid, x_sample[8], y_valid, y_sample[8],
                                 // z_valid, z_sample[8], zero pad[5]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[2], unstable_axes[3], zero pad[3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wmd_pkg::*;

  localparam logic [1:0] PH_FILL    = 2'd0;
  localparam logic [1:0] PH_WATCH   = 2'd1;
  localparam logic [1:0] PH_MOTION  = 2'd2;
  localparam logic [1:0] PH_TIMEOUT = 2'd3;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [1:0] REG_MIN_SIMILAR = 2'd0;
  localparam logic [1:0] REG_TOLERANCE   = 2'd1;
  localparam logic [1:0] REG_MAX_TICKS   = 2'd2;

  logic [1:0]           state;
  logic [1:0]           phase;
  logic [1:0]           phase_next;
  logic [TICK_W-1:0]    tick;
  logic [TICK_W-1:0]    tick_next;
  logic [TICK_W-1:0]    tick_inc;
  logic [2:0]           last_unst;
  logic [2:0]           last_unst_next;
  logic [WIN_IDX_W-1:0] eval_cnt;
  logic                 req_kind;
  logic [NUM_AXES-1:0]  smp_valid;
  logic [SMP_W-1:0]     smp [NUM_AXES];
  logic [MIN_W-1:0]     min_similar;
  logic [TOL_W-1:0]     similar_tolerance;
  logic [LIMIT_W-1:0]   max_watch_ticks;
  logic [1:0]           out_status;
  logic [2:0]           out_unst;

  logic                 accept;
  logic                 fire;
  logic                 do_clear;
  logic [NUM_AXES-1:0]  push;
  logic [NUM_AXES-1:0]  still;
  logic [NUM_AXES-1:0]  full_after;
  axis_ctl_t            ctl [NUM_AXES];
  axis_sts_t            sts [NUM_AXES];

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign fire      = (state == ST_WRITE) && (!m_tvalid || m_tready);
  assign cfg_ready = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_similar       <= MIN_W'(8);
      similar_tolerance <= TOL_W'(1);
      max_watch_ticks   <= LIMIT_W'(1000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_SIMILAR: min_similar       <= cfg_data[MIN_W-1:0];
        REG_TOLERANCE:   similar_tolerance <= cfg_data[TOL_W-1:0];
        REG_MAX_TICKS:   max_watch_ticks   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the request for the duration of its processing
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= s_tuser;
      smp_valid <= {s_tdata[18], s_tdata[9], s_tdata[0]};
      smp[0]    <= s_tdata[8:1];
      smp[1]    <= s_tdata[17:10];
      smp[2]    <= s_tdata[26:19];
    end
  end

  assign tick_inc = (tick == {TICK_W{1'b1}}) ? tick : tick + 1'b1;

  always_comb begin
    phase_next     = phase;
    tick_next      = tick;
    last_unst_next = last_unst;
    push           = '0;
    do_clear       = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      full_after[a] = sts[a].full || (push[a] && sts[a].last_slot);
    end
    if (req_kind == REQ_RESTART) begin
      do_clear       = 1'b1;
      phase_next     = PH_FILL;
      tick_next      = '0;
      last_unst_next = '0;
    end else begin
      unique case (phase)
        PH_FILL: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            push[a]       = smp_valid[a] && !sts[a].full;
            full_after[a] = sts[a].full || (push[a] && sts[a].last_slot);
          end
          if (&full_after) begin
            phase_next = PH_WATCH;
          end
        end
        PH_WATCH: begin
          if (~still != '0) begin
            last_unst_next = ~still;
            phase_next     = PH_MOTION;
          end else begin
            push      = smp_valid;
            tick_next = tick_inc;
            if (tick_inc > TICK_W'(max_watch_ticks)) begin
              phase_next = PH_TIMEOUT;
            end
          end
        end
        default: ;  // final status: repeat it
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_FILL;
      tick      <= '0;
      last_unst <= '0;
      eval_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            eval_cnt <= '0;
            if (s_tuser == REQ_TICK && phase == PH_WATCH) begin
              state <= ST_EVAL;
            end else begin
              state <= ST_WRITE;
            end
          end
        end
        ST_EVAL: begin
          eval_cnt <= eval_cnt + 1'b1;
          if (eval_cnt == WIN_IDX_W'(WINDOW - 1)) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (fire) begin
            phase     <= phase_next;
            tick      <= tick_next;
            last_unst <= last_unst_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result valid: set on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= phase_next;
      out_unst   <= (phase_next == PH_MOTION) ? last_unst_next : 3'b000;
    end
  end

  assign m_tdata = {3'b000, out_unst, out_status};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    always_comb begin
      ctl[a].clear      = fire && do_clear;
      ctl[a].push       = fire && push[a];
      ctl[a].rotate     = (state == ST_EVAL);
      ctl[a].eval_start = accept && s_tuser == REQ_TICK && phase == PH_WATCH;
    end

    wmd_axis u_axis (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[a]),
      .sample  (smp[a]),
      .tol     (similar_tolerance),
      .min_sim (min_similar),
      .sts     (sts[a])
    );

    assign still[a] = sts[a].still;
  end

endmodule

FILE: src/wmd_axis.sv
`timescale 1ns / 1ps
// One axis of the motion detector: sample shift line, fill count and the
// compare unit that tests one candidate against the whole window per cycle.
// Depends on wmd_pkg.
module wmd_axis (
  input  logic                             clk,
  input  logic                             rst,
  input  wmd_pkg::axis_ctl_t               ctl,
  input  logic signed [wmd_pkg::SMP_W-1:0] sample,
  input  logic        [wmd_pkg::TOL_W-1:0] tol,
  input  logic        [wmd_pkg::MIN_W-1:0] min_sim,
  output wmd_pkg::axis_sts_t               sts
);
  import wmd_pkg::*;

  logic signed [SMP_W-1:0] win [WINDOW];
  logic        [CNT_W-1:0] fill;
  logic                    still;
  logic        [WINDOW-1:0] hit;
  logic        [CNT_W-1:0] hits;
  logic signed [SMP_W-1:0] shift_in;

  // candidate is always entry 0; rotation brings every entry there in turn
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      logic signed [SMP_W:0] diff;
      logic        [SMP_W:0] mag;
      diff = {win[0][SMP_W-1], win[0]} - {win[k][SMP_W-1], win[k]};
      mag = diff[SMP_W] ? (SMP_W+1)'(-diff) : diff;
      hit[k] = (mag <= {1'b0, tol});
    end
    hits = CNT_W'($countones(hit));
  end

  assign shift_in = ctl.rotate ? win[0] : sample;

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.rotate) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WINDOW-1] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      still <= 1'b0;
    end else begin
      if (ctl.clear) begin
        fill <= '0;
      end else if (ctl.push && fill != CNT_W'(WINDOW)) begin
        fill <= fill + 1'b1;
      end
      if (ctl.eval_start) begin
        still <= 1'b0;
      end else if (ctl.rotate && CMP_W'(hits) >= CMP_W'(min_sim)) begin
        still <= 1'b1;
      end
    end
  end

  assign sts.full      = (fill == CNT_W'(WINDOW));
  assign sts.last_slot = (fill == CNT_W'(WINDOW - 1));
  assign sts.still     = still;

endmodule
